[hw/rtl/mnd_pkg.sv]
// Shared constants, types and codes for the masked neighborhood dilation unit.
`timescale 1ns / 1ps
package mnd_pkg;

    // Image store geometry; both sizes are powers of two so an address is {row, col}.
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int DIM_W   = 9;
    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = 4;
    localparam int COUNT_W = 4;
    localparam int SUM_W   = 12;
    localparam int PIX_W   = NUM_CH * CHAN_W + 1;

    // Divider lane: quotient known to fit DIV_Q_W bits.
    localparam int DIV_NUM_W = 13;
    localparam int DIV_DEN_W = 9;
    localparam int DIV_Q_W   = 8;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRAP,
        ST_CALC,
        ST_READ,
        ST_DRAIN,
        ST_AVG,
        ST_AVG_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        col;
        logic [7:0]        row_pos;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              covered;
    } item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

[hw/rtl/masked_neighborhood_dilation_unit.sv]
// Top level: configuration registers, image store, sequencer and output register.
//
//  Channel   Signals                                           Direction
//  config    cfg_we, cfg_index, cfg_data                       in, write only
//  input     in_valid/in_ready, kind, col, row_pos, *_in       in
//  output    out_valid/out_ready, *_out, covered_count         out
//
// After reset a clearing pass writes every one of the 65536 store entries, one per
// cycle, and no item is taken during the pass; configuration writes are.
// A pixel write is taken in the idle state. A query whose centre lies inside the
// image goes to the store reads; one outside it is first reduced by the divider
// lanes. The nine store reads share one read port, and the lanes form the averages.
// A finished result sits in the output register, so the next item can be taken
// while it waits; a second result waits in the sequencer until the register frees.
`timescale 1ns / 1ps
module masked_neighborhood_dilation_unit
    import mnd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [DIM_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [7:0]        col,
    input  logic [7:0]        row_pos,
    input  logic [CHAN_W-1:0] red_in,
    input  logic [CHAN_W-1:0] green_in,
    input  logic [CHAN_W-1:0] blue_in,
    input  logic [CHAN_W-1:0] alpha_in,
    input  logic              covered_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAN_W-1:0] red_out,
    output logic [CHAN_W-1:0] green_out,
    output logic [CHAN_W-1:0] blue_out,
    output logic [CHAN_W-1:0] alpha_out,
    output logic [COUNT_W-1:0] covered_count
);

    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg;
    result_t           res;
    logic              res_valid;
    logic              out_free;
    item_t             item;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [PIX_W-1:0]  mem_wdata, mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Zero acts as one, and anything above the store size acts as the store size.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign item = '{kind: kind, col: col, row_pos: row_pos, alpha: alpha_in,
                    blue: blue_in, green: green_in, red: red_in, covered: covered_in};

    assign out_free = !out_valid_reg || out_ready;

    mnd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mnd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item      (item),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_out       = res_reg.red;
    assign green_out     = res_reg.green;
    assign blue_out      = res_reg.blue;
    assign alpha_out     = res_reg.alpha;
    assign covered_count = res_reg.count;

endmodule

[hw/rtl/mnd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module mnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/mnd_div.sv]
// Restoring divider lane that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module mnd_div
    import mnd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_Q_W-1:0]   quot,
    output logic [DIV_DEN_W-1:0] rem
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] part_reg, part_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_Q_W-1:0]   low_reg, low_next;
    logic [DIV_Q_W-1:0]   quot_reg, quot_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        part_next = part_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        trial     = {part_reg, low_reg[DIV_Q_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        if (start)
        begin
            // The quotient fits DIV_Q_W bits, so the high part is already below the divisor.
            busy_next = 1'b1;
            cnt_next  = '0;
            part_next = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
            low_next  = num[DIV_Q_W-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            part_next = qbit ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            low_next  = {low_reg[DIV_Q_W-2:0], 1'b0};
            quot_next = {quot_reg[DIV_Q_W-2:0], qbit};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        den_reg  <= den_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = part_reg;

endmodule

[hw/rtl/mnd_core.sv]
// Sequencer: store clearing, pixel writes, neighborhood reads, sums and averaging.
`timescale 1ns / 1ps
module mnd_core
    import mnd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  item_t              item,
    input  logic [DIM_W-1:0]   w_eff,
    input  logic [DIM_W-1:0]   h_eff,
    input  logic               out_free,
    output logic               res_valid,
    output result_t            res,
    output logic               mem_we,
    output logic [ADDR_W-1:0]  mem_waddr,
    output logic [PIX_W-1:0]   mem_wdata,
    output logic               mem_re,
    output logic [ADDR_W-1:0]  mem_raddr,
    input  logic [PIX_W-1:0]   mem_rdata
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [1:0]          dx_reg, dx_next;
    logic [1:0]          dy_reg, dy_next;
    logic                pend_reg, pend_next;
    logic [COL_W-1:0]    cx_reg, cx_next;
    logic [ROW_W-1:0]    cy_reg, cy_next;
    logic [COL_W-1:0]    xs_reg [3];
    logic [ROW_W-1:0]    ys_reg [3];
    logic [SUM_W-1:0]    sum_reg [NUM_CH];
    logic [COUNT_W-1:0]  cnt_reg;

    logic                in_range;
    logic                div_start;
    logic                div_avg;
    logic                load_taps;
    logic [DIV_NUM_W-1:0] div_num  [NUM_CH];
    logic [DIV_DEN_W-1:0] div_den  [NUM_CH];
    logic [NUM_CH-1:0]    div_done;
    logic [DIV_Q_W-1:0]   div_quot [NUM_CH];
    logic [DIV_DEN_W-1:0] div_rem  [NUM_CH];

    assign in_range = ({1'b0, item.col} < w_eff) && ({1'b0, item.row_pos} < h_eff);
    assign div_avg  = (state_reg == ST_AVG);

    // Lanes 0 and 1 reduce the query centre; all four lanes later form the averages.
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (div_avg)
            begin
                div_num[i] = DIV_NUM_W'({sum_reg[i], 1'b0}) + DIV_NUM_W'(cnt_reg);
                div_den[i] = DIV_DEN_W'({cnt_reg, 1'b0});
            end
            else
            begin
                div_num[i] = '0;
                div_den[i] = DIV_DEN_W'(1);
            end
        end
        if (!div_avg)
        begin
            div_num[0] = DIV_NUM_W'(item.col);
            div_den[0] = w_eff;
            div_num[1] = DIV_NUM_W'(item.row_pos);
            div_den[1] = h_eff;
        end
    end

    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_lane
        mnd_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (div_num[g]),
            .den   (div_den[g]),
            .done  (div_done[g]),
            .quot  (div_quot[g]),
            .rem   (div_rem[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        in_ready   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = {item.row_pos[ROW_W-1:0], item.col[COL_W-1:0]};
        mem_wdata  = {item.covered, item.alpha, item.blue, item.green, item.red};
        mem_re     = 1'b0;
        mem_raddr  = {ys_reg[dy_reg], xs_reg[dx_reg]};
        div_start  = 1'b0;
        load_taps  = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (item.kind == KIND_WRITE)
                    begin
                        mem_we = in_range;
                    end
                    else if (in_range)
                    begin
                        cx_next    = item.col[COL_W-1:0];
                        cy_next    = item.row_pos[ROW_W-1:0];
                        state_next = ST_CALC;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_WRAP;
                    end
                end
            end
            ST_WRAP:
            begin
                if (div_done[0])
                begin
                    cx_next    = div_rem[0][COL_W-1:0];
                    cy_next    = div_rem[1][ROW_W-1:0];
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                load_taps  = 1'b1;
                dx_next    = '0;
                dy_next    = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                mem_re = 1'b1;
                if (dx_reg == 2'd2)
                begin
                    dx_next = '0;
                    dy_next = dy_reg + 1'b1;
                    if (dy_reg == 2'd2)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                div_start  = 1'b1;
                state_next = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (div_done[0])
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pend_next = mem_re;

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            res = '0;
        end
        else
        begin
            res.red   = div_quot[0];
            res.green = div_quot[1];
            res.blue  = div_quot[2];
            res.alpha = div_quot[3];
            res.count = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            pend_reg  <= pend_next;
        end
    end

    // Wrapped neighbor coordinates, sums and the covered count.
    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        if (load_taps)
        begin
            xs_reg[0] <= (cx_reg == '0) ? COL_W'(w_eff - 1'b1) : cx_reg - 1'b1;
            xs_reg[1] <= cx_reg;
            xs_reg[2] <= ((DIM_W'(cx_reg) + 1'b1) >= w_eff) ? '0 : cx_reg + 1'b1;
            ys_reg[0] <= (cy_reg == '0) ? ROW_W'(h_eff - 1'b1) : cy_reg - 1'b1;
            ys_reg[1] <= cy_reg;
            ys_reg[2] <= ((DIM_W'(cy_reg) + 1'b1) >= h_eff) ? '0 : cy_reg + 1'b1;
            for (int i = 0; i < NUM_CH; i++)
            begin
                sum_reg[i] <= '0;
            end
            cnt_reg <= '0;
        end
        else if (pend_reg && mem_rdata[PIX_W-1])
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                sum_reg[i] <= sum_reg[i] + SUM_W'(mem_rdata[i*CHAN_W +: CHAN_W]);
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule
